[src/nvr_pkg.sv]
package nvr_pkg;

  localparam int unsigned LumaAw   = 18;
  localparam int unsigned ChromaAw = 17;
  localparam int unsigned CfgW     = 10;
  localparam int unsigned CoordW   = 9;
  localparam int unsigned DivNumW  = 19;
  localparam int unsigned MulAW    = 10;
  localparam int unsigned MulBW    = 17;
  localparam int unsigned MulPW    = MulAW + MulBW;

  localparam logic [CfgW-1:0] MaxOutSize = 10'd512;

  localparam logic [CfgW-1:0] RstSrcWidth  = 10'd512;
  localparam logic [CfgW-1:0] RstSrcHeight = 10'd512;
  localparam logic [CfgW-1:0] RstOutSize   = 10'd320;
  localparam logic [CfgW-1:0] RstLumaStr   = 10'd512;
  localparam logic [CfgW-1:0] RstChromaStr = 10'd512;

  // bt.601 full range, q16
  localparam logic [MulBW-1:0] QRv = 17'd91881;
  localparam logic [MulBW-1:0] QGu = 17'd22554;
  localparam logic [MulBW-1:0] QGv = 17'd46802;
  localparam logic [MulBW-1:0] QBu = 17'd116130;

  typedef enum logic [1:0] {
    CMD_LUMA   = 2'd0,
    CMD_CHROMA = 2'd1,
    CMD_EMIT   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_OUT_SIZE   = 3'd2,
    CFG_LUMA_STR   = 3'd3,
    CFG_CHROMA_STR = 3'd4
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_MULX,
    ST_DSTX,
    ST_WAITX,
    ST_MULY,
    ST_DSTY,
    ST_WAITY,
    ST_LADDR,
    ST_CADDR,
    ST_RDL,
    ST_RDV,
    ST_RDU,
    ST_GETU,
    ST_MRV,
    ST_MGU,
    ST_MGV,
    ST_MBU,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic                luma_we;
    logic                chroma_we;
    logic [LumaAw-1:0]   wr_addr;
    logic [7:0]          wr_data;
    logic                luma_re;
    logic [LumaAw-1:0]   luma_raddr;
    logic                chroma_re;
    logic [ChromaAw-1:0] chroma_raddr;
  } store_req_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [CfgW-1:0]    divisor;
  } div_req_t;

endpackage

[src/nvr_div.sv]
module nvr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  nvr_pkg::div_req_t         req_i,
  output logic                      done_o,
  output logic [nvr_pkg::DivNumW-1:0] quot_o
);
  import nvr_pkg::*;

  localparam int unsigned CntW = $clog2(DivNumW + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CfgW-1:0]     rem_q, rem_d;
  logic [CfgW-1:0]     dvs_q, dvs_d;
  logic [DivNumW-1:0]  quo_q, quo_d;
  logic [CfgW:0]       rem_sh;
  logic                ge;

  // restoring divider, one quotient bit a cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[DivNumW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivNumW);
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = ge ? CfgW'(rem_sh - {1'b0, dvs_q}) : rem_sh[CfgW-1:0];
      quo_d = {quo_q[DivNumW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

[src/nvr_store.sv]
module nvr_store (
  input  logic                        clk_i,
  input  nvr_pkg::store_req_t         req_i,
  output logic [7:0]                  luma_rdata_o,
  output logic [7:0]                  chroma_rdata_o
);
  import nvr_pkg::*;

  localparam int unsigned LumaDepth   = 1 << LumaAw;
  localparam int unsigned ChromaDepth = 1 << ChromaAw;

  logic [7:0] luma_mem   [LumaDepth];
  logic [7:0] chroma_mem [ChromaDepth];
  logic [7:0] luma_rd_q;
  logic [7:0] chroma_rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.luma_we) begin
      luma_mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.luma_re) begin
      luma_rd_q <= luma_mem[req_i.luma_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.chroma_we) begin
      chroma_mem[req_i.wr_addr[ChromaAw-1:0]] <= req_i.wr_data;
    end
    if (req_i.chroma_re) begin
      chroma_rd_q <= chroma_mem[req_i.chroma_raddr];
    end
  end

  assign luma_rdata_o   = luma_rd_q;
  assign chroma_rdata_o = chroma_rd_q;

endmodule

[src/nv21_resize_to_rgb.sv]
// load words (luma or chroma byte writes) are written at the accepting edge
// an emit word makes two passes of the shared restoring divider
// for the source coordinates, then uses one shared multiplier and single-port store reads
// the result waits in an output register; a new word is taken once the block is back in idle
// reset clears the sequencer, counters, output valid and configuration registers to defaults;
// store contents are undefined until written
module nv21_resize_to_rgb (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // address[17:0], data_byte[25:18], zero pad
  input  logic [1:0]  s_axis_tuser,   // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import nvr_pkg::*;

  localparam int unsigned AccW = 11;

  function automatic logic [7:0] clamp8(input logic signed [AccW-1:0] x);
    logic [7:0] r;
    if (x < 0) begin
      r = 8'd0;
    end else if (x > 255) begin
      r = 8'd255;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [CfgW-1:0] src_w_q, src_h_q, out_sz_q, l_str_q, c_str_q;
  logic            cfg_we;
  cfg_idx_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = cfg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= RstSrcWidth;
      src_h_q  <= RstSrcHeight;
      out_sz_q <= RstOutSize;
      l_str_q  <= RstLumaStr;
      c_str_q  <= RstChromaStr;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SRC_WIDTH:  src_w_q  <= pwdata[CfgW-1:0];
        CFG_SRC_HEIGHT: src_h_q  <= pwdata[CfgW-1:0];
        CFG_OUT_SIZE:   out_sz_q <= pwdata[CfgW-1:0];
        CFG_LUMA_STR:   l_str_q  <= pwdata[CfgW-1:0];
        CFG_CHROMA_STR: c_str_q  <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_SRC_WIDTH:  prdata = 32'(src_w_q);
      CFG_SRC_HEIGHT: prdata = 32'(src_h_q);
      CFG_OUT_SIZE:   prdata = 32'(out_sz_q);
      CFG_LUMA_STR:   prdata = 32'(l_str_q);
      CFG_CHROMA_STR: prdata = 32'(c_str_q);
      default:        prdata = '0;
    endcase
  end

  // sequencer and datapath state
  state_e state_q, state_d;

  logic [CoordW-1:0]   row_q, col_q;
  logic [CfgW-1:0]     size_q;
  logic [CfgW-1:0]     sx_q, sy_q;
  logic [LumaAw-1:0]   li_q;
  logic [ChromaAw-1:0] ci_q;
  logic [7:0]          v_q;
  logic [MulPW-1:0]    mul_q;
  logic signed [AccW-1:0] r_q, g_q;
  logic                ovalid_q;
  logic [23:0]         opix_q;
  logic                olast_q;

  logic [MulAW-1:0]    mul_a;
  logic [MulBW-1:0]    mul_b;
  logic                mul_en;

  store_req_t          sreq;
  div_req_t            dreq;
  logic [7:0]          luma_rd, chroma_rd;
  logic                div_done;
  logic [DivNumW-1:0]  div_quot;

  logic                in_acc;
  cmd_e                cmd;
  logic [CfgW-1:0]     size_eff;
  logic                wrap;
  logic                out_free;

  logic [7:0]          v_mag, u_mag;
  logic                v_neg, u_neg;
  logic signed [AccW-1:0] term;
  logic signed [AccW-1:0] y_s, b_val;
  logic                last_pix;

  assign cmd    = cmd_e'(s_axis_tuser);
  assign in_acc = s_axis_tvalid & s_axis_tready;

  always_comb begin
    if (out_sz_q == '0) begin
      size_eff = CfgW'(1);
    end else if (out_sz_q > MaxOutSize) begin
      size_eff = MaxOutSize;
    end else begin
      size_eff = out_sz_q;
    end
  end

  assign wrap     = ({1'b0, row_q} >= size_eff) || ({1'b0, col_q} >= size_eff);
  assign out_free = !ovalid_q || m_axis_tready;

  // d = byte - 128, split into sign and magnitude
  assign v_neg = !v_q[7];
  assign v_mag = v_neg ? 8'(9'd128 - {1'b0, v_q}) : {1'b0, v_q[6:0]};
  assign u_neg = !chroma_rd[7];
  assign u_mag = u_neg ? 8'(9'd128 - {1'b0, chroma_rd}) : {1'b0, chroma_rd[6:0]};

  // truncated-toward-zero product from the last multiply
  always_comb begin
    logic neg;
    neg  = (state_q == ST_MGU || state_q == ST_MBU) ? v_neg : u_neg;
    term = neg ? -AccW'($signed({3'b000, mul_q[23:16]}))
               : AccW'($signed({3'b000, mul_q[23:16]}));
  end

  assign y_s      = AccW'($signed({3'b000, luma_rd}));
  assign b_val    = y_s + term;
  assign last_pix = ({1'b0, row_q} == size_q - 1'b1) && ({1'b0, col_q} == size_q - 1'b1);

  always_comb begin
    state_d = state_q;
    mul_en  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    sreq    = '0;
    dreq    = '0;
    s_axis_tready = 1'b0;

    sreq.wr_addr      = s_axis_tdata[LumaAw-1:0];
    sreq.wr_data      = s_axis_tdata[LumaAw+7:LumaAw];
    sreq.luma_raddr   = li_q;
    sreq.chroma_raddr = ci_q;
    dreq.divisor      = size_q;
    dreq.dividend     = mul_q[DivNumW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          unique case (cmd)
            CMD_LUMA:   sreq.luma_we   = 1'b1;
            CMD_CHROMA: sreq.chroma_we = 1'b1;
            CMD_EMIT:   state_d        = ST_PREP;
            CMD_NONE:   ;
            default:    ;
          endcase
        end
      end
      ST_PREP: state_d = ST_MULX;
      ST_MULX: begin
        mul_en  = 1'b1;
        mul_a   = src_w_q;
        mul_b   = MulBW'(col_q);
        state_d = ST_DSTX;
      end
      ST_DSTX: begin
        dreq.start = 1'b1;
        state_d    = ST_WAITX;
      end
      ST_WAITX: if (div_done) state_d = ST_MULY;
      ST_MULY: begin
        mul_en  = 1'b1;
        mul_a   = src_h_q;
        mul_b   = MulBW'(row_q);
        state_d = ST_DSTY;
      end
      ST_DSTY: begin
        dreq.start = 1'b1;
        state_d    = ST_WAITY;
      end
      ST_WAITY: if (div_done) state_d = ST_LADDR;
      ST_LADDR: begin
        mul_en  = 1'b1;
        mul_a   = l_str_q;
        mul_b   = MulBW'(sy_q);
        state_d = ST_CADDR;
      end
      ST_CADDR: begin
        mul_en  = 1'b1;
        mul_a   = c_str_q;
        mul_b   = MulBW'(sy_q[CfgW-1:1]);
        state_d = ST_RDL;
      end
      ST_RDL: begin
        sreq.luma_re = 1'b1;
        state_d      = ST_RDV;
      end
      ST_RDV: begin
        sreq.chroma_re = 1'b1;
        state_d        = ST_RDU;
      end
      ST_RDU: begin
        sreq.chroma_re    = 1'b1;
        sreq.chroma_raddr = ci_q + 1'b1;
        state_d           = ST_GETU;
      end
      ST_GETU: state_d = ST_MRV;
      ST_MRV: begin
        mul_en  = 1'b1;
        mul_a   = MulAW'(v_mag);
        mul_b   = QRv;
        state_d = ST_MGU;
      end
      ST_MGU: begin
        mul_en  = 1'b1;
        mul_a   = MulAW'(u_mag);
        mul_b   = QGu;
        state_d = ST_MGV;
      end
      ST_MGV: begin
        mul_en  = 1'b1;
        mul_a   = MulAW'(v_mag);
        mul_b   = QGv;
        state_d = ST_MBU;
      end
      ST_MBU: begin
        mul_en  = 1'b1;
        mul_a   = MulAW'(u_mag);
        mul_b   = QBu;
        state_d = ST_FIN;
      end
      ST_FIN: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      row_q    <= '0;
      col_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PREP && wrap) begin
        row_q <= '0;
        col_q <= '0;
      end
      if (state_q == ST_FIN && out_free) begin
        ovalid_q <= 1'b1;
        if ({1'b0, col_q} + 1'b1 >= size_q) begin
          col_q <= '0;
          row_q <= ({1'b0, row_q} + 1'b1 >= size_q) ? '0 : row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end else if (ovalid_q && m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      mul_q <= mul_a * mul_b;
    end
    unique case (state_q)
      ST_PREP:  size_q <= size_eff;
      ST_WAITX: if (div_done) sx_q <= div_quot[CfgW-1:0];
      ST_WAITY: if (div_done) sy_q <= div_quot[CfgW-1:0];
      ST_CADDR: li_q <= LumaAw'(mul_q + MulPW'(sx_q));
      ST_RDL:   ci_q <= ChromaAw'(mul_q + MulPW'({sx_q[CfgW-1:1], 1'b0}));
      ST_RDU:   v_q  <= chroma_rd;
      ST_MGU:   r_q  <= y_s + term;
      ST_MGV:   g_q  <= y_s - term;
      ST_MBU:   g_q  <= g_q - term;
      ST_FIN: begin
        if (out_free) begin
          opix_q  <= {clamp8(b_val), clamp8(g_q), clamp8(r_q)};
          olast_q <= last_pix;
        end
      end
      default: ;
    endcase
  end

  nvr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  nvr_store u_store (
    .clk_i          (clk_i),
    .req_i          (sreq),
    .luma_rdata_o   (luma_rd),
    .chroma_rdata_o (chroma_rd)
  );

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = opix_q;
  assign m_axis_tlast  = olast_q;

  // unused input bits and accept strobe
  logic unused_in;
  assign unused_in = ^{s_axis_tdata[31:LumaAw+8], in_acc, paddr[1:0], pwdata[31:CfgW]};

endmodule
